// File: hw/rtl/fsd_pkg.sv
// ---------------------------------------------------------------------------
// fsd_pkg: shared types for the framebuffer shape drawer
// Command codes, the decoded command passed from the front end to the
// drawing engine, and the engine status bundle.
// ---------------------------------------------------------------------------
`default_nettype none

package fsd_pkg;

   localparam int COORD_W = 10;
   localparam int MODE_W  = 3;

   typedef logic signed [COORD_W-1:0] coord_type;

   localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PIXEL = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LINE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RECT  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FILL  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_READ  = 3'd5;

   typedef enum logic [2:0] {
      KIND_CLEAR,
      KIND_LINE,
      KIND_RECT,
      KIND_FILL,
      KIND_READ,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type  kind;
      coord_type x_a;
      coord_type y_a;
      coord_type x_b;
      coord_type y_b;
   } fsd_cmd_type;

   typedef struct packed {
      logic booting;
      logic busy;
   } fsd_back_stat_type;

endpackage

`default_nettype wire

// File: hw/rtl/fsd_front.sv
// ---------------------------------------------------------------------------
// fsd_front: command intake and decode
// Accepts commands, decodes them into drawing jobs and holds them in a
// two-entry queue for the drawing engine.
// ---------------------------------------------------------------------------
`default_nettype none

module fsd_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [39:0]              req_tdata,   // x_a, y_a, x_b, y_b
   input  logic [2:0]               req_tuser,   // mode
   input  fsd_pkg::fsd_back_stat_type stat,
   output logic                     cmd_valid,
   input  logic                     cmd_ready,
   output fsd_pkg::fsd_cmd_type     cmd
);
   import fsd_pkg::*;

   fsd_cmd_type ent_ff [2];
   logic        wr_ff, wr_in;
   logic        rd_ff, rd_in;
   logic [1:0]  cnt_ff, cnt_in;
   fsd_cmd_type dec;
   coord_type   xa, ya, xb, yb;
   logic        push, pop;

   assign xa = coord_type'(req_tdata[9:0]);
   assign ya = coord_type'(req_tdata[19:10]);
   assign xb = coord_type'(req_tdata[29:20]);
   assign yb = coord_type'(req_tdata[39:30]);

   // classify; a pixel is a line of zero length, a reversed fill is a no-op
   always_comb begin
      dec.x_a = xa;
      dec.y_a = ya;
      dec.x_b = xb;
      dec.y_b = yb;
      unique case (req_tuser)
         MODE_CLEAR: dec.kind = KIND_CLEAR;
         MODE_PIXEL: begin
            dec.kind = KIND_LINE;
            dec.x_b  = xa;
            dec.y_b  = ya;
         end
         MODE_LINE:  dec.kind = KIND_LINE;
         MODE_RECT:  dec.kind = KIND_RECT;
         MODE_FILL:  dec.kind = (xa > xb) ? KIND_NOP : KIND_FILL;
         MODE_READ:  dec.kind = KIND_READ;
         default:    dec.kind = KIND_NOP;
      endcase
   end

   assign req_tready = (cnt_ff != 2'd2) && !stat.booting;
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = ent_ff[rd_ff];

   assign wr_in  = push ? !wr_ff : wr_ff;
   assign rd_in  = pop ? !rd_ff : rd_ff;
   assign cnt_in = 2'(cnt_ff + {1'b0, push} - {1'b0, pop});

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ff] <= dec;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/fsd_back.sv
// ---------------------------------------------------------------------------
// fsd_back: drawing engine
// Walks lines one pixel per cycle into the frame store, sweeps the store
// for clear, reads single pixels and registers the result.
// ---------------------------------------------------------------------------
`default_nettype none

module fsd_back #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   output logic                        cmd_ready,
   input  fsd_pkg::fsd_cmd_type        cmd,
   output fsd_pkg::fsd_back_stat_type  stat,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata
);
   import fsd_pkg::*;

   localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam logic signed [11:0] W_S = 12'(SCREEN_WIDTH);
   localparam logic signed [11:0] H_S = 12'(SCREEN_HEIGHT);

   typedef enum logic [2:0] {
      ST_WIPE, ST_IDLE, ST_SETUP, ST_STEP, ST_READ, ST_READ_WAIT, ST_FINISH
   } state_type;

   state_type          state_ff;
   fsd_cmd_type        cmd_ff;
   logic               boot_ff;
   logic [AW-1:0]      wipe_addr_ff;
   logic [1:0]         side_ff;
   coord_type          col_ff;
   logic               xmaj_ff, neg_ff;
   logic signed [11:0] maj_ff, q_ff;
   logic signed [13:0] r_ff;
   logic signed [11:0] d2_ff;
   logic [11:0]        dd_ff;
   logic [10:0]        cnt_ff;
   logic               plot_ff;
   logic signed [11:0] plot_x_ff, plot_y_ff;
   logic               value_ff, rsp_valid_ff, rsp_bit_ff;
   logic               rd_bit_ff, rd_on_ff;
   logic               mem [DEPTH];

   // current line end points
   coord_type          xs, ys, xe, ye;
   logic signed [10:0] dx, dy;
   logic [10:0]        ax, ay, span;
   logic               xmaj, line_last;

   always_comb begin
      xs = cmd_ff.x_a;
      ys = cmd_ff.y_a;
      xe = cmd_ff.x_b;
      ye = cmd_ff.y_b;
      priority if (cmd_ff.kind == KIND_FILL) begin
         xs = col_ff;
         xe = col_ff;
      end else if (cmd_ff.kind == KIND_RECT) begin
         unique case (side_ff)
            2'd0: begin xs = cmd_ff.x_a; ys = cmd_ff.y_a; xe = cmd_ff.x_a; ye = cmd_ff.y_b; end
            2'd1: begin xs = cmd_ff.x_b; ys = cmd_ff.y_a; xe = cmd_ff.x_b; ye = cmd_ff.y_b; end
            2'd2: begin xs = cmd_ff.x_a; ys = cmd_ff.y_a; xe = cmd_ff.x_b; ye = cmd_ff.y_a; end
            default: begin xs = cmd_ff.x_a; ys = cmd_ff.y_b; xe = cmd_ff.x_b; ye = cmd_ff.y_b; end
         endcase
      end else begin
         xs = cmd_ff.x_a;
      end
   end

   assign dx   = 11'(xe) - 11'(xs);
   assign dy   = 11'(ye) - 11'(ys);
   assign ax   = dx[10] ? 11'(-dx) : 11'(dx);
   assign ay   = dy[10] ? 11'(-dy) : 11'(dy);
   assign xmaj = ax > ay;
   assign span = xmaj ? ax : ay;

   always_comb begin
      priority if (cmd_ff.kind == KIND_RECT) begin
         line_last = (side_ff == 2'd3);
      end else if (cmd_ff.kind == KIND_FILL) begin
         line_last = (col_ff == cmd_ff.x_b);
      end else begin
         line_last = 1'b1;
      end
   end

   // one step: floor quotient and remainder move by at most one divisor
   logic signed [11:0] maj_n, q_n, minor;
   logic signed [13:0] r_t, r_n, dd_s;

   assign dd_s  = $signed({2'b00, dd_ff});
   assign maj_n = neg_ff ? maj_ff - 12'sd1 : maj_ff + 12'sd1;
   assign r_t   = r_ff + 14'(d2_ff);

   always_comb begin
      priority if (r_t >= dd_s) begin
         r_n = r_t - dd_s;
         q_n = q_ff + 12'sd1;
      end else if (r_t < 14'sd0) begin
         r_n = r_t + dd_s;
         q_n = q_ff - 12'sd1;
      end else begin
         r_n = r_t;
         q_n = q_ff;
      end
   end

   // floor to truncation toward zero
   assign minor = (q_n < 12'sd0 && r_n != 14'sd0) ? q_n + 12'sd1 : q_n;

   // write port stage
   logic          plot_on, rd_on;
   logic [AW-1:0] plot_addr, rd_addr;

   assign plot_on = plot_x_ff >= 12'sd0 && plot_x_ff < W_S &&
                    plot_y_ff >= 12'sd0 && plot_y_ff < H_S;
   assign plot_addr = AW'($unsigned(plot_y_ff)) * AW'(SCREEN_WIDTH)
                    + AW'($unsigned(plot_x_ff));
   assign rd_on = 12'(cmd_ff.x_a) >= 12'sd0 && 12'(cmd_ff.x_a) < W_S &&
                  12'(cmd_ff.y_a) >= 12'sd0 && 12'(cmd_ff.y_a) < H_S;
   assign rd_addr = AW'($unsigned(cmd_ff.y_a)) * AW'(SCREEN_WIDTH)
                  + AW'($unsigned(cmd_ff.x_a));

   always_ff @(posedge clock) begin
      if (plot_ff && plot_on) begin
         mem[plot_addr] <= 1'b1;
      end else if (state_ff == ST_WIPE) begin
         mem[wipe_addr_ff] <= 1'b0;
      end
      if (state_ff == ST_READ) begin
         rd_bit_ff <= mem[rd_addr];
      end
   end

   assign cmd_ready    = (state_ff == ST_IDLE);
   assign stat.booting = boot_ff;
   assign stat.busy    = (state_ff != ST_IDLE);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {7'd0, rsp_bit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         boot_ff      <= 1'b1;
         wipe_addr_ff <= '0;
         plot_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a pixel leaves the stepper on every setup and step cycle
         plot_ff <= (state_ff == ST_SETUP) || (state_ff == ST_STEP);
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_WIPE: begin
               wipe_addr_ff <= wipe_addr_ff + 1'b1;
               if (wipe_addr_ff == AW'(DEPTH - 1)) begin
                  boot_ff  <= 1'b0;
                  state_ff <= boot_ff ? ST_IDLE : ST_FINISH;
               end
            end
            ST_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff       <= cmd;
                  side_ff      <= 2'd0;
                  col_ff       <= cmd.x_a;
                  value_ff     <= 1'b0;
                  wipe_addr_ff <= '0;
                  unique case (cmd.kind)
                     KIND_CLEAR: state_ff <= ST_WIPE;
                     KIND_LINE, KIND_RECT, KIND_FILL: state_ff <= ST_SETUP;
                     KIND_READ:  state_ff <= ST_READ;
                     default:    state_ff <= ST_FINISH;
                  endcase
               end
            end
            ST_SETUP: begin
               // plot the start pixel and load the stepper
               plot_x_ff <= 12'(xs);
               plot_y_ff <= 12'(ys);
               xmaj_ff   <= xmaj;
               neg_ff    <= xmaj ? dx[10] : dy[10];
               maj_ff    <= xmaj ? 12'(xs) : 12'(ys);
               q_ff      <= xmaj ? 12'(ys) : 12'(xs);
               r_ff      <= $signed({3'b000, span});
               d2_ff     <= xmaj ? {dy, 1'b0} : {dx, 1'b0};
               dd_ff     <= {span, 1'b0};
               cnt_ff    <= span;
               if (span != 11'd0) begin
                  state_ff <= ST_STEP;
               end else if (line_last) begin
                  state_ff <= ST_FINISH;
               end else begin
                  side_ff <= side_ff + 2'd1;
                  col_ff  <= col_ff + 10'sd1;
               end
            end
            ST_STEP: begin
               plot_x_ff <= xmaj_ff ? maj_n : minor;
               plot_y_ff <= xmaj_ff ? minor : maj_n;
               maj_ff    <= maj_n;
               q_ff      <= q_n;
               r_ff      <= r_n;
               cnt_ff    <= cnt_ff - 11'd1;
               if (cnt_ff == 11'd1) begin
                  if (line_last) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     side_ff  <= side_ff + 2'd1;
                     col_ff   <= col_ff + 10'sd1;
                     state_ff <= ST_SETUP;
                  end
               end
            end
            ST_READ: begin
               rd_on_ff <= rd_on;
               state_ff <= ST_READ_WAIT;
            end
            ST_READ_WAIT: begin
               value_ff <= rd_bit_ff & rd_on_ff;
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_bit_ff   <= value_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/framebuffer_shape_drawer_unit.sv
// Throughput: one store write per cycle, one command in the engine at a time.
// Reset: synchronous; a wipe pass over all SCREEN_WIDTH*SCREEN_HEIGHT locations clears
//   the frame store, and req_tready stays low until it ends.
// ---------------------------------------------------------------------------
// framebuffer_shape_drawer_unit: monochrome line, rectangle and fill engine
// Front end decodes and queues commands, the engine draws into a one-bit
// frame store and answers each command with one result transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module framebuffer_shape_drawer_unit #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // x_a[9:0], y_a[19:10], x_b[29:20], y_b[39:30]
   input  logic [2:0]  req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // pixel_value[0], zeros above
);
   import fsd_pkg::*;

   fsd_cmd_type       cmd;
   logic              cmd_valid, cmd_ready;
   fsd_back_stat_type stat;

   // intake: decode and queue each command transaction
   fsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   // engine: walk lines, sweep the store, read pixels, hold the result
   fsd_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   // no command taken while the store is still being wiped after reset
   a_boot_gate: assert property (@(posedge clock) disable iff (reset)
      stat.booting |-> !req_tready)
      else $error("command accepted during boot wipe");

   // a result shows up only from a busy engine
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(stat.busy))
      else $error("result without engine activity");

   // a command taken while idle sets the engine busy
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd_ready |=> stat.busy)
      else $error("engine did not start on command");
`endif

endmodule

`default_nettype wire
